### sv/otsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package otsu_pkg;

  localparam int MaxPixelsLog2Default = 22;
  localparam int Bins = 256;

  typedef struct packed {
    logic pix_take;
    logic pix_write;
    logic scan_acc;
    logic scan_prod;
    logic scan_diff;
    logic sq_init;
    logic sq_step;
    logic mul_init;
    logic mul_step;
    logic take;
    logic t_next;
    logic finish;
  } otsu_cmd_t;

  typedef struct packed {
    logic last;
    logic n1_zero;
    logic n0_zero;
    logic have;
    logic greater;
    logic t_last;
  } otsu_stat_t;

endpackage
`default_nettype wire

### sv/otsu_threshold_finder.sv
`timescale 1ns / 1ps
`default_nettype none
// Otsu threshold finder for 8-bit gray images.
// Input: pulse start_i with pixel_i / last_i; an item is taken at a clock edge
// where start_i is high and busy_o is low. Each pixel is handled in two steps
// (histogram bin read, then increment write to the bin memory).
// At most 2^MAX_PIXELS_LOG2 - 1 pixels are counted per image; extra pixels
// are dropped, but last_i still starts the scan.
// After the pixel flagged last, busy_o stays high while the bins are scanned
// from 0 up to 255, or until no pixels lie above the current bin. Per bin:
// read, accumulate and check; a scored candidate adds the difference and the
// serial square in the shift-add unit, and once a best candidate exists the
// serial cross products and the compare.
// Output: threshold_o with valid_o high for exactly one cycle; the receiver
// cannot stall. The histogram is then cleared at once by its valid bits.
// Reset: asynchronous, active low; histogram and counts read as empty.
module otsu_threshold_finder #(
  parameter int MAX_PIXELS_LOG2 = otsu_pkg::MaxPixelsLog2Default
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [7:0] pixel_i,
  input  wire logic       last_i,
  output logic            valid_o,
  output logic [7:0]      threshold_o
);
  import otsu_pkg::*;

  otsu_cmd_t  cmd;
  otsu_stat_t stat;

  otsu_ctrl #(.MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .valid_o (valid_o)
  );

  otsu_datapath #(.MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pixel_i     (pixel_i),
    .last_i      (last_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .threshold_o (threshold_o)
  );

endmodule
`default_nettype wire

### sv/otsu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module otsu_datapath #(
  parameter int MAX_PIXELS_LOG2 = otsu_pkg::MaxPixelsLog2Default
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         pixel_i,
  input  wire logic               last_i,
  input  wire otsu_pkg::otsu_cmd_t  cmd_i,
  output otsu_pkg::otsu_stat_t      stat_o,
  output logic [7:0]              threshold_o
);
  import otsu_pkg::*;

  localparam int W   = MAX_PIXELS_LOG2;
  localparam int SW  = W + 8;
  localparam int DW  = 2 * W + 8;
  localparam int PW  = 2 * W;
  localparam int SQW = 2 * DW;
  localparam int PRW = SQW + PW;

  logic [W-1:0]   mem [Bins];
  logic [Bins-1:0] vld_q;
  logic [W-1:0]   rdata_q;
  logic           rvld_q;
  logic [7:0]     rd_addr;
  logic [W-1:0]   hval;

  logic [7:0]     pix_q;
  logic           last_q, ok_q;
  logic [W-1:0]   count_q, n0_q;
  logic [SW-1:0]  ssum_q, s0_q;
  logic [7:0]     t_q, best_t_q;
  logic           have_q;
  logic [DW-1:0]  a_q, b_q, d_q, ys_q;
  logic [PW-1:0]  p_q, best_p_q, yl_q, yr_q;
  logic [SQW-1:0] d2_q, xs_q, best_d2_q;
  logic [PRW-1:0] xl_q, xr_q, lacc_q, racc_q;

  assign rd_addr = cmd_i.pix_take ? pixel_i : t_q;
  assign hval    = rvld_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_write && ok_q) begin
      mem[pix_q] <= hval + W'(1);
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvld_q   <= 1'b0;
      count_q  <= '0;
      ssum_q   <= '0;
      n0_q     <= '0;
      s0_q     <= '0;
      t_q      <= '0;
      best_t_q <= '0;
      have_q   <= 1'b0;
      last_q   <= 1'b0;
      ok_q     <= 1'b0;
    end else begin
      rvld_q <= vld_q[rd_addr];
      if (cmd_i.pix_take) begin
        last_q <= last_i;
        ok_q   <= (count_q != {W{1'b1}});
      end
      if (cmd_i.pix_write && ok_q) begin
        vld_q[pix_q] <= 1'b1;
        count_q      <= count_q + W'(1);
        ssum_q       <= ssum_q + SW'(pix_q);
      end
      if (cmd_i.scan_acc) begin
        n0_q <= n0_q + hval;
        s0_q <= s0_q + SW'(t_q) * SW'(hval);
      end
      if (cmd_i.take) begin
        best_t_q <= t_q;
        have_q   <= 1'b1;
      end
      if (cmd_i.t_next) t_q <= t_q + 8'd1;
      if (cmd_i.finish) begin
        vld_q    <= '0;
        count_q  <= '0;
        ssum_q   <= '0;
        n0_q     <= '0;
        s0_q     <= '0;
        t_q      <= '0;
        best_t_q <= '0;
        have_q   <= 1'b0;
      end
    end
  end

  // score arithmetic: products registered, squares and cross products shift-add
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_take) pix_q <= pixel_i;
    if (cmd_i.scan_prod) begin
      a_q <= DW'(count_q) * DW'(s0_q);
      b_q <= DW'(n0_q) * DW'(ssum_q);
      p_q <= PW'(n0_q) * PW'(count_q - n0_q);
    end
    if (cmd_i.scan_diff) d_q <= (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);
    if (cmd_i.sq_init) begin
      xs_q <= SQW'(d_q);
      ys_q <= d_q;
      d2_q <= '0;
    end
    if (cmd_i.sq_step) begin
      if (ys_q[0]) d2_q <= d2_q + xs_q;
      xs_q <= xs_q << 1;
      ys_q <= ys_q >> 1;
    end
    if (cmd_i.mul_init) begin
      xl_q   <= PRW'(d2_q);
      yl_q   <= best_p_q;
      xr_q   <= PRW'(best_d2_q);
      yr_q   <= p_q;
      lacc_q <= '0;
      racc_q <= '0;
    end
    if (cmd_i.mul_step) begin
      if (yl_q[0]) lacc_q <= lacc_q + xl_q;
      if (yr_q[0]) racc_q <= racc_q + xr_q;
      xl_q <= xl_q << 1;
      xr_q <= xr_q << 1;
      yl_q <= yl_q >> 1;
      yr_q <= yr_q >> 1;
    end
    if (cmd_i.take) begin
      best_d2_q <= d2_q;
      best_p_q  <= p_q;
    end
  end

  assign stat_o.last    = last_q;
  assign stat_o.n1_zero = (count_q == n0_q);
  assign stat_o.n0_zero = (n0_q == '0);
  assign stat_o.have    = have_q;
  assign stat_o.greater = (lacc_q > racc_q);
  assign stat_o.t_last  = (t_q == 8'hFF);
  assign threshold_o    = best_t_q;

endmodule
`default_nettype wire

### sv/otsu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module otsu_ctrl #(
  parameter int MAX_PIXELS_LOG2 = otsu_pkg::MaxPixelsLog2Default
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire otsu_pkg::otsu_stat_t stat_i,
  output otsu_pkg::otsu_cmd_t       cmd_o,
  output logic                      busy_o,
  output logic                      valid_o
);
  import otsu_pkg::*;

  localparam int DW = 2 * MAX_PIXELS_LOG2 + 8;
  localparam int PW = 2 * MAX_PIXELS_LOG2;
  localparam int CW = $clog2(DW + 1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_PWR   = 13'b0000000000010,
    S_SREAD = 13'b0000000000100,
    S_SACC  = 13'b0000000001000,
    S_SCHK  = 13'b0000000010000,
    S_SDIFF = 13'b0000000100000,
    S_SQI   = 13'b0000001000000,
    S_SQ    = 13'b0000010000000,
    S_SQE   = 13'b0000100000000,
    S_MUL   = 13'b0001000000000,
    S_CMP   = 13'b0010000000000,
    S_NEXT  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.pix_take = 1'b1;
          state_d = S_PWR;
        end
      end
      S_PWR: begin
        cmd_o.pix_write = 1'b1;
        state_d = stat_i.last ? S_SREAD : S_IDLE;
      end
      S_SREAD: state_d = S_SACC;
      S_SACC: begin
        cmd_o.scan_acc = 1'b1;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (stat_i.n1_zero) begin
          state_d = S_DONE;
        end else if (stat_i.n0_zero) begin
          state_d = S_NEXT;
        end else begin
          cmd_o.scan_prod = 1'b1;
          state_d = S_SDIFF;
        end
      end
      S_SDIFF: begin
        cmd_o.scan_diff = 1'b1;
        state_d = S_SQI;
      end
      S_SQI: begin
        cmd_o.sq_init = 1'b1;
        cnt_d = '0;
        state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq_step = 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          cnt_d = '0;
          state_d = S_SQE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_SQE: begin
        if (!stat_i.have) begin
          cmd_o.take = 1'b1;
          state_d = S_NEXT;
        end else begin
          cmd_o.mul_init = 1'b1;
          cnt_d = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == CW'(PW - 1)) begin
          cnt_d = '0;
          state_d = S_CMP;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_CMP: begin
        cmd_o.take = stat_i.greater;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        if (stat_i.t_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.t_next = 1'b1;
          state_d = S_SREAD;
        end
      end
      S_DONE: begin
        valid_o = 1'b1;
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

### sv/otsu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module otsu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic       last_i,
  input wire logic       valid_o
);

  // a result only comes out of the scan, never while idle
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o) else $error("result strobe while idle");

  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy_o) else $error("block not idle after result");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !valid_o)) else $error("item not held");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_i) |=> ##1 !valid_o)
    else $error("result after a pixel not flagged last");

endmodule

bind otsu_threshold_finder otsu_checker u_otsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .last_i      (last_i),
  .valid_o     (valid_o)
);
`default_nettype wire
